// ===== design/ribc_pkg.sv =====
// ----------------------------------------------------------------------------
// ribc_pkg
// Types, codes and helper functions for the ROM image order and boot
// classifier: request/result structs, magic words, boot CRC signatures.
// ----------------------------------------------------------------------------
package ribc_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int SIZE_BITS      = 24;

	// Word indexes inside the image
	localparam int PAL_WORD   = 'h3E / 4;
	localparam int CRC_FIRST  = 'h40 / 4;
	localparam int CRC_LAST   = 'h9FF / 4;
	localparam int MIN_WORDS  = 'h1000 / 4;

	localparam logic [31:0] MAGIC_BIG  = 32'h8037_1240;
	localparam logic [31:0] MAGIC_HALF = 32'h3780_4012;
	localparam logic [31:0] MAGIC_LE   = 32'h4012_3780;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	localparam logic [31:0] SIG_X101 = 32'h1deb_51a9;
	localparam logic [31:0] SIG_X102 = 32'hc08e_5bd6;
	localparam logic [31:0] SIG_X103 = 32'h03b8_376a;
	localparam logic [31:0] SIG_X105 = 32'hcf7f_41dc;
	localparam logic [31:0] SIG_X106 = 32'hd105_9c6a;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SMALL     = 2'd1;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd2;

	localparam logic [1:0] ORD_BIG  = 2'd0;
	localparam logic [1:0] ORD_HALF = 2'd1;
	localparam logic [1:0] ORD_LE   = 2'd2;

	localparam logic [2:0] CLS_X101 = 3'd0;
	localparam logic [2:0] CLS_X102 = 3'd1;
	localparam logic [2:0] CLS_X103 = 3'd2;
	localparam logic [2:0] CLS_X105 = 3'd3;
	localparam logic [2:0] CLS_X106 = 3'd4;

	typedef struct packed {
		logic [31:0] word_in;
		logic        last_in;
	} in_t;

	typedef struct packed {
		logic [31:0]          word_out;
		logic                 last_out;
		logic [1:0]           status;
		logic [1:0]           byte_order;
		logic                 pal_region;
		logic [2:0]           boot_chip_class;
		logic [31:0]          boot_crc;
		logic [SIZE_BITS-1:0] size_words;
	} out_t;

	function automatic logic [31:0] normalize(input logic [31:0] w, input logic [1:0] order);
		logic [31:0] r;
		unique case (order)
			ORD_HALF: r = {w[23:16], w[31:24], w[7:0], w[15:8]};
			ORD_LE:   r = {w[7:0], w[15:8], w[23:16], w[31:24]};
			default:  r = w;
		endcase
		return r;
	endfunction

	function automatic logic is_pal_letter(input logic [7:0] c);
		logic r;
		unique case (c)
			"D", "F", "H", "I", "L", "P", "S", "U", "W", "X", "Y": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Reflected CRC-32 over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [31:0] crc_word(input logic [31:0] c, input logic [31:0] w);
		logic [31:0] r;
		r = crc_byte(c, w[31:24]);
		r = crc_byte(r, w[23:16]);
		r = crc_byte(r, w[15:8]);
		r = crc_byte(r, w[7:0]);
		return r;
	endfunction

	function automatic logic [2:0] classify(input logic [31:0] crc);
		logic [2:0] r;
		unique case (crc)
			SIG_X101: r = CLS_X101;
			SIG_X102: r = CLS_X102;
			SIG_X103: r = CLS_X103;
			SIG_X105: r = CLS_X105;
			SIG_X106: r = CLS_X106;
			default:  r = CLS_X102;
		endcase
		return r;
	endfunction

endpackage

// ===== design/rom_image_order_and_boot_classifier_unit.sv =====
// Pipeline: a request is held in the input register, and its result is
//   presented from the result register.
// Throughput: one word per cycle unless result_stall holds the pipeline; the CRC-32
//   word step and the byte swap complete between the input and result registers.
// Reset: arst_n clears the pipeline valids and all image state (order, magic,
//   word count, CRC to all ones, PAL flag); the state also restarts after the last word.
// ----------------------------------------------------------------------------
// rom_image_order_and_boot_classifier_unit
// Normalizes a cartridge image stream with a known magic word to big-endian,
// tracks the header region and boot CRC, and reports a verdict on the last word.
// ----------------------------------------------------------------------------
module rom_image_order_and_boot_classifier_unit #(
	parameter int COUNT_BITS = ribc_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           image_valid,
	output logic           image_stall,
	input  ribc_pkg::in_t  image,
	output logic           result_valid,
	input  logic           result_stall,
	output ribc_pkg::out_t result
);
	import ribc_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
	localparam logic [COUNT_BITS-1:0] CNT_PAL   = COUNT_BITS'(PAL_WORD);
	localparam logic [COUNT_BITS-1:0] CNT_FIRST = COUNT_BITS'(CRC_FIRST);
	localparam logic [COUNT_BITS-1:0] CNT_LAST  = COUNT_BITS'(CRC_LAST);
	localparam logic [COUNT_BITS-1:0] CNT_MIN   = COUNT_BITS'(MIN_WORDS);

	logic            valid_s1;
	in_t             item_s1;
	logic            valid_s2;
	out_t            result_s2;

	logic [1:0]            order_q;
	logic                  magic_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [31:0]           crc_q;
	logic                  pal_q;

	logic                  advance;
	logic                  load_s1;
	logic                  first;
	logic                  sat;
	logic [1:0]            order_n;
	logic                  magic_n;
	logic [31:0]           norm;
	logic                  pal_n;
	logic [31:0]           crc_n;
	logic [COUNT_BITS-1:0] count_n;
	logic [31:0]           count_wide;
	logic [31:0]           crc_final;
	out_t                  res_c;

	assign advance      = !valid_s2 || !result_stall;
	assign load_s1      = !valid_s1 || advance;
	assign image_stall  = valid_s1 && !advance;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_comb begin
		first = (count_q == '0);
		sat   = (count_q == CNT_MAX);

		order_n = order_q;
		magic_n = magic_q;
		if (first) begin
			priority if (item_s1.word_in == MAGIC_BIG) begin
				order_n = ORD_BIG;
				magic_n = 1'b1;
			end else if (item_s1.word_in == MAGIC_HALF) begin
				order_n = ORD_HALF;
				magic_n = 1'b1;
			end else if (item_s1.word_in == MAGIC_LE) begin
				order_n = ORD_LE;
				magic_n = 1'b1;
			end else begin
				order_n = ORD_BIG;
				magic_n = 1'b0;
			end
		end

		norm = magic_n ? normalize(item_s1.word_in, order_n) : item_s1.word_in;

		pal_n   = pal_q;
		crc_n   = crc_q;
		count_n = count_q;
		if (!sat) begin
			if (count_q == CNT_PAL) begin
				pal_n = is_pal_letter(norm[15:8]);
			end
			if (count_q >= CNT_FIRST && count_q <= CNT_LAST) begin
				crc_n = crc_word(crc_q, norm);
			end
			count_n = count_q + 1'b1;
		end

		count_wide = 32'(count_n);
		crc_final  = ~crc_n;

		res_c          = '0;
		res_c.word_out = norm;
		res_c.last_out = item_s1.last_in;
		if (item_s1.last_in) begin
			priority if (count_n < CNT_MIN) begin
				res_c.status = ST_SMALL;
			end else if (!magic_n) begin
				res_c.status = ST_BAD_MAGIC;
			end else begin
				res_c.status = ST_OK;
			end
			if (res_c.status == ST_OK) begin
				res_c.byte_order      = order_n;
				res_c.pal_region      = pal_n;
				res_c.boot_chip_class = classify(crc_final);
				res_c.boot_crc        = crc_final;
			end
			res_c.size_words = count_wide[SIZE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= image_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && image_valid) begin
			item_s1 <= image;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= res_c;
		end
	end

	// Image state: update per word, restart after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORD_BIG;
			magic_q <= 1'b0;
			count_q <= '0;
			crc_q   <= CRC_INIT;
			pal_q   <= 1'b0;
		end else if (advance && valid_s1) begin
			if (item_s1.last_in) begin
				order_q <= ORD_BIG;
				magic_q <= 1'b0;
				count_q <= '0;
				crc_q   <= CRC_INIT;
				pal_q   <= 1'b0;
			end else begin
				order_q <= order_n;
				magic_q <= magic_n;
				count_q <= count_n;
				crc_q   <= crc_n;
				pal_q   <= pal_n;
			end
		end
	end

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && item_s1.last_in) |=> (count_q == '0 && crc_q == CRC_INIT))
		else $error("image state not restarted after last word");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_out) |->
		(result.status == ST_OK && result.boot_crc == '0 && result.size_words == '0))
		else $error("verdict fields set on a non-last word");

	a_failed_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_out && result.status != ST_OK) |->
		(result.byte_order == ORD_BIG && result.boot_crc == '0 && !result.pal_region))
		else $error("detail fields set on a failed verdict");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		image_stall |-> (valid_s1 && valid_s2 && result_stall))
		else $error("request stalled with room in the pipeline");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && !item_s1.last_in && count_q != CNT_MAX) |=>
		(count_q == $past(count_q) + 1'b1))
		else $error("word count did not advance");

endmodule
